// File: sv/abl_pkg.sv
// Shared types and codes for the bit link framer.
package abl_pkg;

    localparam logic OP_RX_EVENT = 1'b0;
    localparam logic OP_TX_REQ   = 1'b1;

    localparam logic [1:0] EV_ZERO    = 2'd0;
    localparam logic [1:0] EV_ONE     = 2'd1;
    localparam logic [1:0] EV_CARRIER = 2'd2;
    localparam logic [1:0] EV_OTHER   = 2'd3;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_CARRIER = 2'd1;
    localparam logic [1:0] PH_ACTIVE  = 2'd2;

    localparam int DATA_BITS  = 8;
    localparam int RX_HOLD    = DATA_BITS + 1;
    localparam int TX_QUEUED  = DATA_BITS + 1;
    localparam int CNT_W      = 4;

    localparam logic [CNT_W-1:0] RX_FULL   = CNT_W'(RX_HOLD);
    localparam logic [CNT_W-1:0] TX_FILL   = CNT_W'(TX_QUEUED);

    typedef struct packed {
        logic       opcode;
        logic [1:0] rx_event;
        logic       host_byte_valid;
        logic [7:0] host_byte;
        logic       host_closed;
    } t_in_item;

    typedef struct packed {
        logic       line_bit;
        logic       rx_byte_valid;
        logic [7:0] rx_byte;
        logic       host_byte_taken;
        logic       send_header;
        logic       hang_up;
    } t_out_item;

endpackage

// File: sv/abl_if.sv
// Valid/ready channel interfaces for line events in and results out.
interface abl_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [1:0] rx_event;
    logic       host_byte_valid;
    logic [7:0] host_byte;
    logic       host_closed;

    modport source (output valid, output opcode, output rx_event, output host_byte_valid,
                    output host_byte, output host_closed, input ready);
    modport sink   (input valid, input opcode, input rx_event, input host_byte_valid,
                    input host_byte, input host_closed, output ready);
endinterface

interface abl_out_if;
    logic       valid;
    logic       ready;
    logic       line_bit;
    logic       rx_byte_valid;
    logic [7:0] rx_byte;
    logic       host_byte_taken;
    logic       send_header;
    logic       hang_up;

    modport source (output valid, output line_bit, output rx_byte_valid, output rx_byte,
                    output host_byte_taken, output send_header, output hang_up,
                    input ready);
    modport sink   (input valid, input line_bit, input rx_byte_valid, input rx_byte,
                    input host_byte_taken, input send_header, input hang_up,
                    output ready);
endinterface

// File: sv/async_bit_link_framer_core.sv
// Top level: 8N1 bit link framer and deframer with registered input and result.
//
// Channels: i_in carries one item per transfer, either a demodulator line event
// (opcode 0) or a request for the next transmit bit (opcode 1) together with the
// host byte offer and close flag. o_out returns exactly one result per item:
// the line bit, a received byte strobe, the host byte consumed flag and the
// header and hang-up pulses.
// Path: an item is held in an input register, then its result is computed
// and written to the output register, which offers it on o_out.
// Throughput: one item per cycle unless o_out stalls; the link state, the
// 9-bit receive window and the 9-bit transmit queue update in the same cycle
// the result is computed.
// Reset: link returns to no carrier, the null byte is owed again and both
// queues are emptied; no results are pending.
// Stall: while o_out.ready is low the result holds, one more item waits in the
// input register, and i_in.ready drops only once both registers are full.
module async_bit_link_framer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    abl_in_if.sink    i_in,
    abl_out_if.source o_out
);
    import abl_pkg::*;

    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    logic      r_out_vld;
    t_out_item result;
    logic      advance;
    logic      in_xfer;

    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;
    assign in_xfer    = i_in.valid && i_in.ready;

    abl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.opcode          <= i_in.opcode;
            r_in.rx_event        <= i_in.rx_event;
            r_in.host_byte_valid <= i_in.host_byte_valid;
            r_in.host_byte       <= i_in.host_byte;
            r_in.host_closed     <= i_in.host_closed;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.line_bit        = r_out.line_bit;
    assign o_out.rx_byte_valid   = r_out.rx_byte_valid;
    assign o_out.rx_byte         = r_out.rx_byte;
    assign o_out.host_byte_taken = r_out.host_byte_taken;
    assign o_out.send_header     = r_out.send_header;
    assign o_out.hang_up         = r_out.hang_up;

endmodule

// File: sv/abl_core.sv
// Link state, receive deframing window and transmit bit queue.
module abl_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  abl_pkg::t_in_item i_item,
    output abl_pkg::t_out_item o_result
);
    import abl_pkg::*;

    logic [1:0]         r_phase,   n_phase;
    logic               r_null,    n_null;
    logic [RX_HOLD-1:0] r_rx_sh,   n_rx_sh;
    logic [CNT_W-1:0]   r_rx_cnt,  n_rx_cnt;
    logic [TX_QUEUED-1:0] r_tx_sh, n_tx_sh;
    logic [CNT_W-1:0]   r_tx_cnt,  n_tx_cnt;

    logic               active;
    logic [RX_HOLD:0]   window;
    t_out_item          res;

    assign active = (r_phase != PH_IDLE) && (r_phase != PH_CARRIER);
    assign window = {i_item.rx_event[0], r_rx_sh};

    always_comb begin
        n_phase  = r_phase;
        n_null   = r_null;
        n_rx_sh  = r_rx_sh;
        n_rx_cnt = r_rx_cnt;
        n_tx_sh  = r_tx_sh;
        n_tx_cnt = r_tx_cnt;
        res      = '0;
        res.line_bit = 1'b1;
        if (i_item.opcode == OP_RX_EVENT) begin
            if (!active) begin
                if (i_item.rx_event == EV_CARRIER) begin
                    n_phase = PH_CARRIER;
                end else if (i_item.rx_event == EV_ONE && r_phase == PH_CARRIER) begin
                    n_phase = PH_ACTIVE;
                end
            end else if (i_item.rx_event == EV_ZERO || i_item.rx_event == EV_ONE) begin
                n_rx_sh = window[RX_HOLD:1];
                if (r_rx_cnt != RX_FULL) begin
                    n_rx_cnt = r_rx_cnt + 1'b1;
                end else if (!window[0] && window[RX_HOLD]) begin
                    res.rx_byte_valid = 1'b1;
                    res.rx_byte       = window[DATA_BITS:1];
                    n_rx_cnt          = '0;
                end
            end
        end else if (r_tx_cnt != '0) begin
            res.line_bit = r_tx_sh[0];
            n_tx_sh      = {1'b1, r_tx_sh[TX_QUEUED-1:1]};
            n_tx_cnt     = r_tx_cnt - 1'b1;
        end else if (r_null) begin
            if (i_item.host_byte_valid) begin
                n_tx_sh             = {1'b1, i_item.host_byte};
                n_tx_cnt            = TX_FILL;
                res.host_byte_taken = 1'b1;
                res.line_bit        = 1'b0;
            end else if (i_item.host_closed) begin
                res.hang_up = 1'b1;
            end
        end else if (!i_item.host_byte_valid && i_item.host_closed) begin
            res.hang_up = 1'b1;
        end else if (active) begin
            n_tx_sh         = {1'b1, {DATA_BITS{1'b0}}};
            n_tx_cnt        = TX_FILL;
            n_null          = 1'b1;
            res.send_header = 1'b1;
            res.line_bit    = 1'b0;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_null   <= 1'b0;
            r_rx_cnt <= '0;
            r_tx_cnt <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_null   <= n_null;
            r_rx_cnt <= n_rx_cnt;
            r_tx_cnt <= n_tx_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_rx_sh <= n_rx_sh;
            r_tx_sh <= n_tx_sh;
        end
    end

endmodule
